>>> hw/rtl/csq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_pkg
// Shared constants for the counting semaphore with a FIFO wait queue.
// ----------------------------------------------------------------------------

package csq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_THREADS = 256;

	localparam int THR_W   = 8;
	localparam int CNT_W   = 16;
	localparam int FUNC_W  = 3;
	localparam int KIND_W  = 3;
	localparam int QA_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QF_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SIGNAL  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_WAIT    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DESTROY = 3'd4;

	localparam logic [KIND_W-1:0] KIND_DONE      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GRANTED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WOKE_OK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WOKE_FAIL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FULL      = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SATURATED = 3'd6;
	localparam logic [KIND_W-1:0] KIND_INVALID   = 3'd7;

endpackage

>>> hw/rtl/counting_semaphore_wait_queue_unit.sv
// Create, wait and invalid codes load their result into the output register at dispatch;
// a signal with waiters reads the queue head, emits it, then moves each waiter left down
// one place to close the gap at the head. Cancel scans one entry per cycle and moves
// closed-up entries with a read and then a write each; destroy drains one waiter per cycle
// while the output is free. One operation at a time: input is taken only when idle.
// Reset clears count, fill and control; queue contents are undefined until written.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with a FIFO queue of waiting thread ids, driven by a
// small sequencer over one queue RAM.
// ----------------------------------------------------------------------------

module counting_semaphore_wait_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] thread
	input  logic [2:0]  s_tuser,   // [2:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] woken, [23:8] count
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISP     = 3'd1;
	localparam logic [2:0] S_SIG_RD   = 3'd2;
	localparam logic [2:0] S_CAN_CMP  = 3'd3;
	localparam logic [2:0] S_SHIFT    = 3'd4;
	localparam logic [2:0] S_SHIFT_WR = 3'd5;
	localparam logic [2:0] S_DES      = 3'd6;

	localparam int QA_W = csq_pkg::QA_W;
	localparam int QF_W = csq_pkg::QF_W;

	logic [2:0]                   state_q, state_d;
	logic [csq_pkg::FUNC_W-1:0]   func_q;
	logic [csq_pkg::THR_W-1:0]    thr_q;
	logic [csq_pkg::CNT_W-1:0]    count_q, count_d;
	logic [QF_W-1:0]              fill_q, fill_d;
	logic [QA_W-1:0]              idx_q, idx_d;

	logic                         out_valid_q;
	logic [csq_pkg::KIND_W-1:0]   out_kind_q;
	logic [csq_pkg::THR_W-1:0]    out_woken_q;
	logic [csq_pkg::CNT_W-1:0]    out_count_q;
	logic                         out_last_q;

	logic                         load_out;
	logic [csq_pkg::KIND_W-1:0]   ld_kind;
	logic [csq_pkg::THR_W-1:0]    ld_woken;
	logic                         ld_last;
	logic                         out_free;

	logic                         ram_we, ram_re;
	logic [QA_W-1:0]              ram_waddr, ram_raddr;
	logic [csq_pkg::THR_W-1:0]    ram_wdata, ram_rdata;

	logic                         thr_bad;
	logic [QF_W-1:0]              idx_inc;
	logic [QA_W-1:0]              idx_nxt;
	logic                         in_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign thr_bad  = {1'b0, thr_q} >= (csq_pkg::THR_W + 1)'(csq_pkg::NUM_THREADS);
	assign idx_inc  = QF_W'(idx_q) + QF_W'(1);
	assign idx_nxt  = idx_inc[QA_W-1:0];

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		fill_d    = fill_q;
		idx_d     = idx_q;
		load_out  = 1'b0;
		ld_kind   = csq_pkg::KIND_DONE;
		ld_woken  = '0;
		ld_last   = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = fill_q[QA_W-1:0];
		ram_wdata = thr_q;
		ram_re    = 1'b0;
		ram_raddr = '0;

		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (out_free) begin
					case (func_q)
						csq_pkg::FUNC_CREATE: begin
							count_d  = '0;
							fill_d   = '0;
							load_out = 1'b1;
							state_d  = S_IDLE;
						end
						csq_pkg::FUNC_SIGNAL: begin
							if (fill_q != '0) begin
								ram_re  = 1'b1;
								state_d = S_SIG_RD;
							end else if (count_q == csq_pkg::COUNT_MAX) begin
								ld_kind  = csq_pkg::KIND_SATURATED;
								load_out = 1'b1;
								state_d  = S_IDLE;
							end else begin
								count_d  = count_q + 1'b1;
								load_out = 1'b1;
								state_d  = S_IDLE;
							end
						end
						csq_pkg::FUNC_WAIT: begin
							load_out = 1'b1;
							state_d  = S_IDLE;
							if (thr_bad) begin
								ld_kind = csq_pkg::KIND_INVALID;
							end else if (count_q != '0) begin
								count_d = count_q - 1'b1;
								ld_kind = csq_pkg::KIND_GRANTED;
							end else if (fill_q >= QF_W'(csq_pkg::QUEUE_DEPTH)) begin
								ld_kind = csq_pkg::KIND_FULL;
							end else begin
								ram_we  = 1'b1;
								fill_d  = fill_q + 1'b1;
								ld_kind = csq_pkg::KIND_QUEUED;
							end
						end
						csq_pkg::FUNC_CANCEL: begin
							if (thr_bad) begin
								ld_kind  = csq_pkg::KIND_INVALID;
								load_out = 1'b1;
								state_d  = S_IDLE;
							end else if (fill_q == '0) begin
								load_out = 1'b1;
								state_d  = S_IDLE;
							end else begin
								idx_d   = '0;
								ram_re  = 1'b1;
								state_d = S_CAN_CMP;
							end
						end
						csq_pkg::FUNC_DESTROY: begin
							count_d = '0;
							if (fill_q == '0) begin
								load_out = 1'b1;
								state_d  = S_IDLE;
							end else begin
								idx_d   = '0;
								ram_re  = 1'b1;
								state_d = S_DES;
							end
						end
						default: begin
							ld_kind  = csq_pkg::KIND_INVALID;
							load_out = 1'b1;
							state_d  = S_IDLE;
						end
					endcase
				end
			end
			S_SIG_RD: begin
				// emit the head, then close the gap it leaves
				if (out_free) begin
					ld_kind  = csq_pkg::KIND_WOKE_OK;
					ld_woken = ram_rdata;
					load_out = 1'b1;
					fill_d   = fill_q - 1'b1;
					idx_d    = '0;
					state_d  = S_SHIFT;
				end
			end
			S_CAN_CMP: begin
				if (ram_rdata == thr_q) begin
					fill_d  = fill_q - 1'b1;
					state_d = S_SHIFT;
				end else if (idx_inc >= fill_q) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end else begin
					idx_d     = idx_nxt;
					ram_re    = 1'b1;
					ram_raddr = idx_nxt;
				end
			end
			S_SHIFT: begin
				// fill already holds the new length; move entry idx+1 down to idx
				if (QF_W'(idx_q) < fill_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_nxt;
					state_d   = S_SHIFT_WR;
				end else begin
					// cancel answers after the move; the output is free since dispatch
					load_out = (func_q == csq_pkg::FUNC_CANCEL);
					state_d  = S_IDLE;
				end
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				idx_d     = idx_nxt;
				state_d   = S_SHIFT;
			end
			S_DES: begin
				if (out_free) begin
					ld_kind  = csq_pkg::KIND_WOKE_FAIL;
					ld_woken = ram_rdata;
					load_out = 1'b1;
					ld_last  = (idx_inc == fill_q);
					if (idx_inc == fill_q) begin
						fill_d  = '0;
						state_d = S_IDLE;
					end else begin
						idx_d     = idx_nxt;
						ram_re    = 1'b1;
						ram_raddr = idx_nxt;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= s_tuser;
			thr_q  <= s_tdata;
		end
		if (load_out) begin
			out_kind_q  <= ld_kind;
			out_woken_q <= ld_woken;
			out_count_q <= count_d;
			out_last_q  <= ld_last;
		end
	end

	csq_ram #(
		.WIDTH(csq_pkg::THR_W),
		.DEPTH(csq_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {out_count_q, out_woken_q};
	assign m_tlast  = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QF_W'(csq_pkg::QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_DISP)
		else $error("transfer in not followed by dispatch");

	a_destroy_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DES |-> count_q == '0)
		else $error("count not cleared during destroy drain");

	a_wake_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && ld_kind == csq_pkg::KIND_WOKE_FAIL |-> count_d == '0)
		else $error("failed wake carries nonzero count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !load_out)
		else $error("result overwritten while stalled");

endmodule

>>> hw/rtl/csq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------

module csq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> tb/counting_semaphore_wait_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit_tb
// Self-checking bench for the counting semaphore with a FIFO wait queue. A
// short table of directed operations runs first. Random episodes follow:
// queue fills, mixed traffic, count build-up and noise. Every result
// transfer is checked field by field against a predictor or a directed entry.
// Source and sink idle at random under three idling profiles.
// ----------------------------------------------------------------------------

module counting_semaphore_wait_queue_unit_tb;

	// reserved function codes, answered as invalid
	localparam logic [csq_pkg::FUNC_W-1:0] FUNC_RSVD_LO  = 3'd5;
	localparam logic [csq_pkg::FUNC_W-1:0] FUNC_RSVD_MID = 3'd6;
	localparam logic [csq_pkg::FUNC_W-1:0] FUNC_RSVD_HI  = 3'd7;

	localparam int N_DIRECTED   = 17;
	localparam int ITEMS_PHASE  = 64;
	localparam int DRAIN_CYCLES = 3 * csq_pkg::QUEUE_DEPTH + 16;
	localparam int WAIT_LIMIT   = 200000;

	typedef struct packed {
		logic [csq_pkg::KIND_W-1:0] kind;
		logic [csq_pkg::THR_W-1:0]  woken;
		logic [csq_pkg::CNT_W-1:0]  count;
		logic                       last;
	} sem_result_t;

	typedef struct packed {
		logic [csq_pkg::FUNC_W-1:0] func;
		logic [csq_pkg::THR_W-1:0]  thr;
		logic                       typed;
		logic [csq_pkg::KIND_W-1:0] kind;
		logic [csq_pkg::CNT_W-1:0]  count;
	} sem_vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] thread
	logic [2:0]  s_tuser = '0;   // [2:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [7:0] woken, [23:8] count
	logic [2:0]  m_tuser;        // [2:0] kind
	logic        m_tlast;

	// predictor state
	logic [csq_pkg::CNT_W-1:0] sem_cnt;
	logic [csq_pkg::THR_W-1:0] waiters [$];

	sem_result_t sem_results_new [$];
	sem_result_t sem_results_due [$];
	sem_vec_t    directed_vecs [N_DIRECTED];

	int send_idle = 0;
	int recv_idle = 0;
	int mismatches = 0;

	counting_semaphore_wait_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic sem_put(input logic [csq_pkg::KIND_W-1:0] kind,
			input logic [csq_pkg::THR_W-1:0] woken, input logic last);
		sem_result_t r;
		r.kind  = kind;
		r.woken = woken;
		r.count = sem_cnt;
		r.last  = last;
		sem_results_new.push_back(r);
	endtask

	// advance the semaphore by one operation and collect the results it causes
	task automatic sem_apply(input logic [csq_pkg::FUNC_W-1:0] func,
			input logic [csq_pkg::THR_W-1:0] thr);
		logic [csq_pkg::THR_W-1:0] head;
		int n;
		case (func)
			csq_pkg::FUNC_CREATE: begin
				sem_cnt = '0;
				waiters.delete();
				sem_put(csq_pkg::KIND_DONE, '0, 1'b1);
			end
			csq_pkg::FUNC_SIGNAL: begin
				if (waiters.size() > 0) begin
					head = waiters.pop_front();
					sem_put(csq_pkg::KIND_WOKE_OK, head, 1'b1);
				end else if (sem_cnt == csq_pkg::COUNT_MAX) begin
					sem_put(csq_pkg::KIND_SATURATED, '0, 1'b1);
				end else begin
					sem_cnt = sem_cnt + 1'b1;
					sem_put(csq_pkg::KIND_DONE, '0, 1'b1);
				end
			end
			csq_pkg::FUNC_WAIT: begin
				if (int'(thr) >= csq_pkg::NUM_THREADS) begin
					sem_put(csq_pkg::KIND_INVALID, '0, 1'b1);
				end else if (sem_cnt != '0) begin
					sem_cnt = sem_cnt - 1'b1;
					sem_put(csq_pkg::KIND_GRANTED, '0, 1'b1);
				end else if (waiters.size() >= csq_pkg::QUEUE_DEPTH) begin
					sem_put(csq_pkg::KIND_FULL, '0, 1'b1);
				end else begin
					waiters.push_back(thr);
					sem_put(csq_pkg::KIND_QUEUED, '0, 1'b1);
				end
			end
			csq_pkg::FUNC_CANCEL: begin
				if (int'(thr) >= csq_pkg::NUM_THREADS) begin
					sem_put(csq_pkg::KIND_INVALID, '0, 1'b1);
				end else begin
					// drop only the entry nearest the head
					for (int i = 0; i < waiters.size(); i++) begin
						if (waiters[i] == thr) begin
							waiters.delete(i);
							break;
						end
					end
					sem_put(csq_pkg::KIND_DONE, '0, 1'b1);
				end
			end
			csq_pkg::FUNC_DESTROY: begin
				sem_cnt = '0;
				n = waiters.size();
				if (n == 0)
					sem_put(csq_pkg::KIND_DONE, '0, 1'b1);
				for (int i = 0; i < n; i++)
					sem_put(csq_pkg::KIND_WOKE_FAIL, waiters[i], i == n - 1);
				waiters.delete();
			end
			default: begin
				sem_put(csq_pkg::KIND_INVALID, '0, 1'b1);
			end
		endcase
	endtask

	task automatic send_op(input logic [csq_pkg::FUNC_W-1:0] func,
			input logic [csq_pkg::THR_W-1:0] thr,
			input logic typed = 1'b0, input logic [csq_pkg::KIND_W-1:0] kind = '0,
			input logic [csq_pkg::CNT_W-1:0] count = '0);
		sem_result_t r;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= thr;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sem_apply(func, thr);
		if (typed) begin
			r.kind  = kind;
			r.woken = '0;
			r.count = count;
			r.last  = 1'b1;
			sem_results_new[0] = r;
		end
		while (sem_results_new.size() > 0)
			sem_results_due.push_back(sem_results_new.pop_front());
	endtask

	function automatic logic [csq_pkg::THR_W-1:0] pick_waiter();
		if (waiters.size() == 0)
			return csq_pkg::THR_W'($urandom_range(255));
		return waiters[$urandom_range(waiters.size() - 1)];
	endfunction

	task automatic run_episode(output int n_items);
		int len;
		int pick;
		n_items = 0;
		case ($urandom_range(9))
			0, 1: begin
				// queue waiters, at times past full, cancel a few, then tear down
				send_op(csq_pkg::FUNC_CREATE, csq_pkg::THR_W'($urandom_range(255)));
				len = $urandom_range(12, 20);
				repeat (len)
					send_op(csq_pkg::FUNC_WAIT, ($urandom_range(3) == 0) ? pick_waiter() :
						csq_pkg::THR_W'($urandom_range(255)));
				n_items += len + 1;
				len = $urandom_range(1, 4);
				repeat (len)
					send_op(csq_pkg::FUNC_CANCEL, pick_waiter());
				n_items += len;
				if ($urandom_range(1)) begin
					send_op(csq_pkg::FUNC_SIGNAL, csq_pkg::THR_W'($urandom_range(255)));
					n_items++;
				end
				send_op(csq_pkg::FUNC_DESTROY, csq_pkg::THR_W'($urandom_range(255)));
				n_items++;
			end
			2, 3, 4, 5, 6: begin
				len = $urandom_range(4, 16);
				repeat (len) begin
					pick = $urandom_range(99);
					if (pick < 40)
						send_op(csq_pkg::FUNC_WAIT, csq_pkg::THR_W'($urandom_range(255)));
					else if (pick < 65)
						send_op(csq_pkg::FUNC_SIGNAL, csq_pkg::THR_W'($urandom_range(255)));
					else if (pick < 90)
						send_op(csq_pkg::FUNC_CANCEL,
							($urandom_range(9) < 7) ? pick_waiter() :
							csq_pkg::THR_W'($urandom_range(255)));
					else if (pick < 95)
						send_op(csq_pkg::FUNC_DESTROY, csq_pkg::THR_W'($urandom_range(255)));
					else
						send_op(csq_pkg::FUNC_CREATE, csq_pkg::THR_W'($urandom_range(255)));
				end
				n_items += len;
			end
			7: begin
				// build up a count, take it, then queue behind it
				len = $urandom_range(2, 8);
				repeat (len)
					send_op(csq_pkg::FUNC_SIGNAL, csq_pkg::THR_W'($urandom_range(255)));
				n_items += len;
				len = $urandom_range(1, 10);
				repeat (len)
					send_op(csq_pkg::FUNC_WAIT, csq_pkg::THR_W'($urandom_range(255)));
				n_items += len;
				len = $urandom_range(0, 3);
				repeat (len)
					send_op(csq_pkg::FUNC_SIGNAL, csq_pkg::THR_W'($urandom_range(255)));
				n_items += len;
			end
			default: begin
				len = $urandom_range(1, 4);
				repeat (len)
					send_op(csq_pkg::FUNC_W'($urandom_range(7)),
						csq_pkg::THR_W'($urandom_range(255)));
				n_items += len;
			end
		endcase
	endtask

	always @(posedge clk) begin
		sem_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (sem_results_due.size() == 0) begin
				$display("%0t: unexpected result: kind %0d woken %0h count %0d last %0d",
					$time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
				mismatches++;
			end else begin
				want = sem_results_due.pop_front();
				if (m_tuser !== want.kind || m_tdata[7:0] !== want.woken ||
						m_tdata[23:8] !== want.count || m_tlast !== want.last) begin
					$display("%0t: expected kind %0d woken %0h count %0d last %0d, got %0d %0h %0d %0d",
						$time, want.kind, want.woken, want.count, want.last,
						m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int issued;
		int got;
		int waited;

		directed_vecs = '{
			'{csq_pkg::FUNC_CREATE,  8'h00, 1'b1, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_WAIT,    8'h00, 1'b1, csq_pkg::KIND_QUEUED,  16'd0},
			'{csq_pkg::FUNC_WAIT,    8'hFF, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_WAIT,    8'hAA, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_WAIT,    8'hFF, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_CANCEL,  8'h12, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_CANCEL,  8'hFF, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_SIGNAL,  8'h00, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{FUNC_RSVD_LO,          8'h5A, 1'b1, csq_pkg::KIND_INVALID, 16'd0},
			'{csq_pkg::FUNC_DESTROY, 8'h00, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_DESTROY, 8'hFF, 1'b1, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_SIGNAL,  8'h00, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_SIGNAL,  8'hFF, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{csq_pkg::FUNC_WAIT,    8'h01, 1'b0, csq_pkg::KIND_DONE,    16'd0},
			'{FUNC_RSVD_MID,         8'hA5, 1'b1, csq_pkg::KIND_INVALID, 16'd1},
			'{FUNC_RSVD_HI,          8'h00, 1'b1, csq_pkg::KIND_INVALID, 16'd1},
			'{csq_pkg::FUNC_CREATE,  8'hFF, 1'b1, csq_pkg::KIND_DONE,    16'd0}
		};

		sem_cnt = '0;
		waiters.delete();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 13 : (ph == 1) ? 78 : 0;
			recv_idle = (ph == 0) ? 78 : (ph == 1) ? 13 : 0;
			if (ph == 0) begin
				foreach (directed_vecs[i])
					send_op(directed_vecs[i].func, directed_vecs[i].thr,
						directed_vecs[i].typed, directed_vecs[i].kind,
						directed_vecs[i].count);
			end
			issued = 0;
			while (issued < ITEMS_PHASE) begin
				run_episode(got);
				issued += got;
			end
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (sem_results_due.size() != 0 && waited < WAIT_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sem_results_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sem_results_due.size());
			mismatches++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("%0t: timeout", $time);
		$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/csq_pkg.sv
hw/rtl/csq_ram.sv
hw/rtl/counting_semaphore_wait_queue_unit.sv
tb/counting_semaphore_wait_queue_unit_tb.sv
